// ----- design/lzeb_pkg.sv -----
// Shared constants and types for the escape-byte LZ decompressor.
`timescale 1ns / 1ps

package lzeb_pkg;

    localparam int HIST_AW    = 16;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int BW_W       = HIST_AW + 1;
    localparam int MD_W       = 25;
    localparam int LEN_W      = 13;
    localparam int CR_W       = 14;
    localparam int LEN_BIAS   = 4;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_DRAIN   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_BAD_DIST = 2'd2;

    localparam logic [1:0] PH_TOKEN = 2'd0;
    localparam logic [1:0] PH_CODE  = 2'd1;
    localparam logic [1:0] PH_EXT   = 2'd2;
    localparam logic [1:0] PH_DIST  = 2'd3;

    localparam logic [1:0] KIND_NO_DIST = 2'd3;

    typedef struct packed {
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } hist_req_t;

endpackage

// ----- design/lzeb_history.sv -----
// History ring memory with last-write forwarding for back-to-back copies.
`timescale 1ns / 1ps

module lzeb_history (
    input  logic               clk,
    input  logic               rst_n,
    input  lzeb_pkg::hist_req_t req,
    output logic [7:0]         rd_data
);
    import lzeb_pkg::*;

    logic [7:0]         mem [HIST_DEPTH];
    logic [7:0]         q_reg;
    logic [HIST_AW-1:0] rd_addr_reg;
    logic [HIST_AW-1:0] lw_addr_reg;
    logic [7:0]         lw_data_reg;
    logic               lw_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg       <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
        if (req.wr_en)
        begin
            lw_addr_reg <= req.wr_addr;
            lw_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (req.wr_en)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    // the write landing on the read edge is not seen by the array read
    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : q_reg;

endmodule

// ----- design/lz_escape_byte_decompressor.sv -----
// Top level: escape-byte LZ77 decompressor with history ring and output register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, opcode, in_byte      | into block
//  out     | out_valid, out_ready, out_byte, status,  | out of block
//          | copy_last                                |
//  cfg     | cfg_valid, cfg_ready, cfg_data           | into block
//
// One item per cycle while in_ready is high; an accepted item passes stage one
// (history read), then the forwarding select into the output register, to out_valid.
// Reset clears parse state and escape_key; history contents are undefined.
// in_ready drops only while a result waits in stage one behind a full,
// stalled output register. cfg_ready is always high.
`timescale 1ns / 1ps

module lz_escape_byte_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       copy_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import lzeb_pkg::*;

    logic [7:0]         key_reg;
    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [BW_W-1:0]    bw_reg, bw_next;
    logic [1:0]         phase_reg, phase_next;
    logic [7:0]         tc_reg, tc_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [MD_W-1:0]    md_reg, md_next;
    logic [1:0]         dbl_reg, dbl_next;
    logic [CR_W-1:0]    cr_reg, cr_next;

    logic               s1_valid_reg;
    logic               s1_res_reg;
    logic               s1_mem_reg;
    logic               s1_wr_reg;
    logic [HIST_AW-1:0] s1_addr_reg;
    logic [7:0]         s1_byte_reg;
    logic [1:0]         s1_status_reg;
    logic               s1_last_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic [1:0]         status_reg;
    logic               copy_last_reg;

    logic               accept;
    logic               s1_go;
    logic               c_res, c_mem, c_wr, c_last, c_rd, al, fin;
    logic [7:0]         c_byte;
    logic [1:0]         c_status;
    logic [7:0]         tc_v, al_code;
    logic [MD_W-1:0]    dist_base, dist_p1;
    logic [2:0]         n_full;
    logic [1:0]         n_sel;
    logic [7:0]         s1_byte_val;
    logic [7:0]         hist_q;
    hist_req_t          hreq;

    assign s1_go     = !s1_valid_reg || !s1_res_reg || !out_valid_reg || out_ready;
    assign in_ready  = s1_go;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign tc_v = (in_byte > key_reg) ? in_byte - 8'd1 : in_byte;

    always_comb
    begin
        wp_next    = wp_reg;
        bw_next    = bw_reg;
        phase_next = phase_reg;
        tc_next    = tc_reg;
        len_next   = len_reg;
        md_next    = md_reg;
        dbl_next   = dbl_reg;
        cr_next    = cr_reg;
        c_res      = 1'b0;
        c_mem      = 1'b0;
        c_wr       = 1'b0;
        c_rd       = 1'b0;
        c_last     = 1'b0;
        c_byte     = 8'd0;
        c_status   = ST_OK;
        al         = 1'b0;
        al_code    = tc_reg;
        fin        = 1'b0;
        dist_base  = md_reg;
        dist_p1    = '0;
        n_full     = 3'd0;
        n_sel      = 2'd0;

        case (opcode)
            OP_BYTE:
            begin
                if (cr_reg != '0)
                begin
                    c_res    = 1'b1;
                    c_status = ST_BUSY;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (in_byte != key_reg)
                            begin
                                c_wr   = 1'b1;
                                c_res  = 1'b1;
                                c_byte = in_byte;
                            end
                            else
                            begin
                                phase_next = PH_CODE;
                            end
                        end
                        PH_CODE:
                        begin
                            if (in_byte == key_reg)
                            begin
                                phase_next = PH_TOKEN;
                                c_wr       = 1'b1;
                                c_res      = 1'b1;
                                c_byte     = in_byte;
                            end
                            else
                            begin
                                tc_next  = tc_v;
                                len_next = LEN_W'(tc_v[7:3]);
                                if (tc_v[2])
                                begin
                                    phase_next = PH_EXT;
                                end
                                else
                                begin
                                    al      = 1'b1;
                                    al_code = tc_v;
                                end
                            end
                        end
                        PH_EXT:
                        begin
                            len_next = {in_byte, len_reg[4:0]};
                            al       = 1'b1;
                            al_code  = tc_reg;
                        end
                        default:
                        begin
                            n_full = {1'b0, tc_reg[1:0]} + 3'd1 - {1'b0, dbl_reg};
                            n_sel  = (n_full > 3'd2) ? 2'd2 : n_full[1:0];
                            case (n_sel)
                                2'd0:    dist_base[7:0]   = md_reg[7:0] | in_byte;
                                2'd1:    dist_base[15:8]  = md_reg[15:8] | in_byte;
                                default: dist_base[23:16] = md_reg[23:16] | in_byte;
                            endcase
                            md_next  = dist_base;
                            dbl_next = (dbl_reg == 2'd0) ? 2'd0 : dbl_reg - 2'd1;
                            if (dbl_next == 2'd0)
                            begin
                                fin = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_DRAIN:
            begin
                if (cr_reg != '0)
                begin
                    c_rd    = 1'b1;
                    c_wr    = 1'b1;
                    c_mem   = 1'b1;
                    c_res   = 1'b1;
                    c_last  = (cr_reg == CR_W'(1));
                    cr_next = cr_reg - CR_W'(1);
                end
            end
            OP_RESTART:
            begin
                wp_next    = '0;
                bw_next    = '0;
                phase_next = PH_TOKEN;
                tc_next    = '0;
                len_next   = '0;
                md_next    = '0;
                dbl_next   = 2'd0;
                cr_next    = '0;
            end
            default:
            begin
            end
        endcase

        if (al)
        begin
            md_next   = '0;
            dist_base = '0;
            if (al_code[1:0] == KIND_NO_DIST)
            begin
                fin = 1'b1;
            end
            else
            begin
                dbl_next   = al_code[1:0] + 2'd1;
                phase_next = PH_DIST;
            end
        end

        if (fin)
        begin
            dist_p1    = dist_base + MD_W'(1);
            phase_next = PH_TOKEN;
            dbl_next   = 2'd0;
            if ((dist_p1 > MD_W'(HIST_DEPTH)) || (dist_p1 > MD_W'(bw_reg)))
            begin
                c_res    = 1'b1;
                c_status = ST_BAD_DIST;
            end
            else
            begin
                md_next = dist_p1;
                cr_next = CR_W'(len_next) + CR_W'(LEN_BIAS);
            end
        end

        if (c_wr)
        begin
            wp_next = wp_reg + HIST_AW'(1);
            if (bw_reg != BW_W'(HIST_DEPTH))
            begin
                bw_next = bw_reg + BW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= 8'd0;
            wp_reg    <= '0;
            bw_reg    <= '0;
            phase_reg <= PH_TOKEN;
            tc_reg    <= '0;
            len_reg   <= '0;
            md_reg    <= '0;
            dbl_reg   <= 2'd0;
            cr_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_data;
            end
            if (accept)
            begin
                wp_reg    <= wp_next;
                bw_reg    <= bw_next;
                phase_reg <= phase_next;
                tc_reg    <= tc_next;
                len_reg   <= len_next;
                md_reg    <= md_next;
                dbl_reg   <= dbl_next;
                cr_reg    <= cr_next;
            end
        end
    end

    // stage one: item decoded, history read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            s1_wr_reg    <= 1'b0;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= accept;
            s1_res_reg   <= c_res;
            s1_wr_reg    <= c_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && accept)
        begin
            s1_mem_reg    <= c_mem;
            s1_addr_reg   <= wp_reg;
            s1_byte_reg   <= c_byte;
            s1_status_reg <= c_status;
            s1_last_reg   <= c_last;
        end
    end

    assign s1_byte_val = s1_mem_reg ? hist_q : s1_byte_reg;

    always_comb
    begin
        hreq.rd_en   = accept && c_rd;
        hreq.rd_addr = wp_reg - md_reg[HIST_AW-1:0];
        hreq.wr_en   = s1_valid_reg && s1_wr_reg && s1_go;
        hreq.wr_addr = s1_addr_reg;
        hreq.wr_data = s1_byte_val;
    end

    lzeb_history u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hreq),
        .rd_data (hist_q)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_res_reg && s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_res_reg && s1_go)
        begin
            out_byte_reg  <= s1_byte_val;
            status_reg    <= s1_status_reg;
            copy_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign copy_last = copy_last_reg;

endmodule
